// File: sv/rgb_box_blur_unit_assert.svh
// ----------------------------------------------------------------------------
// RGB box blur assertion macros
// Clocked property checks, empty when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_BLUR_UNIT_ASSERT_SVH
`define RGB_BOX_BLUR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RBB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rgb box blur check failed");
`define RBB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rgb box blur check failed");
`else
`define RBB_ASSERT(label, prop)
`define RBB_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: sv/rbb_pkg.sv
// ----------------------------------------------------------------------------
// RGB box blur package
// Shared widths, register indices, job type and the divider step.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 15;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 16;
  localparam int RING_W     = 5;
  localparam int ADDR_W     = RING_W + COL_W;
  localparam int PIX_W      = 24;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 10;
  localparam int STEP_W     = 5;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;

  typedef struct packed {
    logic [ROW_W-1:0] r0;
    logic [ROW_W-1:0] r1;
    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] c1;
    logic             last;
  } job_t;

  typedef struct packed {
    logic [CNT_W-1:0] rem;
    logic [SUM_W-1:0] quo;
  } div_t;

  // One restoring division step: the quotient bit shifts in from the right.
  function automatic div_t div_step(div_t cur, logic [CNT_W-1:0] d);
    logic [CNT_W:0] sh;
    div_t           res;
    sh = {cur.rem, cur.quo[SUM_W-1]};
    res.quo = {cur.quo[SUM_W-2:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      sh = sh - {1'b0, d};
      res.quo[0] = 1'b1;
    end
    res.rem = sh[CNT_W-1:0];
    return res;
  endfunction

endpackage

// File: sv/rbb_line_mem.sv
// ----------------------------------------------------------------------------
// RGB box blur line store
// Ring of 32 lines, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rbb_line_mem
  import rbb_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [2**ADDR_W];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rbb_front.sv
// ----------------------------------------------------------------------------
// RGB box blur front end
// Stores pixels, tracks positions, and queues one averaging job per output.
// ----------------------------------------------------------------------------
module rbb_front
  import rbb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic [7:0]       in_red_in,
  input  logic [7:0]       in_green_in,
  input  logic [7:0]       in_blue_in,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             back_busy,
  input  logic             job_pop,
  output logic             job_valid,
  output job_t             job,
  output logic             mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [PIX_W-1:0] mem_wdata
);

  logic [3:0]       radius_r;
  logic [10:0]      width_r;
  logic [15:0]      height_r;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  job_t             q_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;

  logic [3:0]       eff_r;
  logic [10:0]      eff_w;
  logic [15:0]      eff_h;
  logic [ROW_W:0]   row_sum;
  logic [COL_W:0]   col_sum, col_inc, ocol_inc;
  logic [ROW_W-1:0] need_row, h_m1;
  logic [COL_W-1:0] need_col, w_m1;
  logic             accept, store, ready_out, push;
  job_t             job_new;

  assign eff_r = radius_r;
  assign eff_w = (width_r == 11'd0) ? 11'd1 :
                 (width_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_r;
  assign eff_h = (height_r == 16'd0) ? 16'd1 : height_r;
  assign h_m1  = eff_h - 16'd1;
  assign w_m1  = COL_W'(eff_w - 11'd1);

  // Only take a request when no job is queued and the back end is not
  // reading, so the ring is never overwritten under a window still being read.
  assign in_ready  = (cnt_r == 2'd0) && !back_busy;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign store     = (in_opcode == OP_PIXEL) && (in_row_r < eff_h);

  assign mem_we    = accept && store;
  assign mem_waddr = {in_row_r[RING_W-1:0], in_col_r};
  assign mem_wdata = {in_red_in, in_green_in, in_blue_in};

  assign col_inc = {1'b0, in_col_r} + (COL_W+1)'(1);

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (store) begin
      if (col_inc >= eff_w) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  assign row_sum  = {1'b0, out_row_r} + (ROW_W+1)'(eff_r);
  assign col_sum  = {1'b0, out_col_r} + (COL_W+1)'(eff_r);
  assign need_row = (row_sum > {1'b0, h_m1}) ? h_m1 : row_sum[ROW_W-1:0];
  assign need_col = (col_sum > {1'b0, w_m1}) ? w_m1 : col_sum[COL_W-1:0];
  assign ready_out = (in_row_nxt > need_row) ||
                     ((in_row_nxt == need_row) && (in_col_nxt > need_col));

  assign job_new.r0   = (out_row_r >= ROW_W'(eff_r)) ? out_row_r - ROW_W'(eff_r) : '0;
  assign job_new.r1   = need_row;
  assign job_new.c0   = (out_col_r >= COL_W'(eff_r)) ? out_col_r - COL_W'(eff_r) : '0;
  assign job_new.c1   = need_col;
  assign job_new.last = (out_row_r == h_m1) && (out_col_r == w_m1);
  assign push         = accept && ready_out;
  assign ocol_inc     = {1'b0, out_col_r} + (COL_W+1)'(1);

  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= 4'd3;
      width_r   <= 11'd1024;
      height_r  <= 16'd768;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RADIUS: radius_r <= cfg_data[3:0];
          CFG_WIDTH:  width_r  <= cfg_data[10:0];
          CFG_HEIGHT: height_r <= cfg_data;
          default:    ;
        endcase
        if (cfg_index == CFG_RADIUS || cfg_index == CFG_WIDTH ||
            cfg_index == CFG_HEIGHT) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end
      end else if (accept) begin
        in_col_r <= in_col_nxt;
        in_row_r <= in_row_nxt;
        if (ready_out) begin
          if (job_new.last) begin
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
          end else if (ocol_inc >= eff_w) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + ROW_W'(1);
          end else begin
            out_col_r <= ocol_inc[COL_W-1:0];
          end
        end
      end
      if (push) begin
        q_r[wr_ptr_r] <= job_new;
        wr_ptr_r      <= !wr_ptr_r;
      end
      if (job_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(job_pop);
    end
  end

endmodule

// File: sv/rbb_back.sv
// ----------------------------------------------------------------------------
// RGB box blur back end
// Sums one window from the line store, divides serially, holds the result.
// ----------------------------------------------------------------------------
module rbb_back
  import rbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  job_t              job,
  output logic              job_pop,
  output logic              busy,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [PIX_W-1:0]  mem_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out,
  output logic              out_frame_end
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_DONE} state_t;

  state_t           state_r;
  job_t             job_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             issue_done_r, rd_vld_r;
  logic [CNT_W-1:0] n_r;
  logic [STEP_W-1:0] step_r;
  div_t             dv_r [3];
  logic             out_valid_r, frame_end_r;
  logic [7:0]       res_r [3];

  assign job_pop       = (state_r == S_IDLE) && job_valid;
  assign busy          = (state_r == S_READ);
  assign mem_raddr     = {row_r[RING_W-1:0], col_r};
  assign out_valid     = out_valid_r;
  assign out_red_out   = res_r[0];
  assign out_green_out = res_r[1];
  assign out_blue_out  = res_r[2];
  assign out_frame_end = frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In the done state the output register is either empty, being
      // emptied, or still holding; in every case it ends up full.
      if (state_r == S_DONE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r        <= job;
            row_r        <= job.r0;
            col_r        <= job.c0;
            issue_done_r <= 1'b0;
            n_r          <= '0;
            for (int i = 0; i < 3; i++) begin
              dv_r[i] <= '0;
            end
            state_r <= S_READ;
          end
        end
        S_READ: begin
          rd_vld_r <= !issue_done_r;
          if (!issue_done_r) begin
            if (col_r == job_r.c1) begin
              col_r <= job_r.c0;
              if (row_r == job_r.r1) begin
                issue_done_r <= 1'b1;
              end else begin
                row_r <= row_r + ROW_W'(1);
              end
            end else begin
              col_r <= col_r + COL_W'(1);
            end
          end
          if (rd_vld_r) begin
            n_r <= n_r + CNT_W'(1);
            for (int i = 0; i < 3; i++) begin
              dv_r[i].quo <= dv_r[i].quo + SUM_W'(mem_rdata[PIX_W-1-8*i -: 8]);
            end
          end
          // The last read has landed once issuing is over and nothing is
          // left in the read register.
          if (issue_done_r && !rd_vld_r) begin
            step_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            dv_r[i] <= div_step(dv_r[i], n_r);
          end
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(SUM_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            for (int i = 0; i < 3; i++) begin
              res_r[i] <= dv_r[i].quo[7:0];
            end
            frame_end_r <= job_r.last;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/rgb_box_blur_unit.sv
// ----------------------------------------------------------------------------
// RGB box blur unit
// Streaming clipped-window mean filter over raster-order 24-bit pixels.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  in        in_valid/in_ready, in_opcode, in_*_in     request in
//  out       out_valid/out_ready, out_*_out, frame_end result out
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  register write
//
//  A request with a result sums the clipped window's N pixels (N up to 961):
//  one line store read a cycle, then an 18-step serial divide.
//  Reset is synchronous and active low; the line store is not cleared.
//  A waiting result is held in the output register while the next window is
//  summed; after a request that yields a result the next one is taken only
//  once its window has been read, or later while an earlier result waits.
// ----------------------------------------------------------------------------
`include "rgb_box_blur_unit_assert.svh"

module rgb_box_blur_unit
  import rbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic              back_busy, job_pop, job_valid, mem_we;
  job_t              job;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [PIX_W-1:0]  mem_wdata, mem_rdata;

  rbb_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_red_in, .in_green_in,
    .in_blue_in, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .back_busy,
    .job_pop, .job_valid, .job, .mem_we, .mem_waddr, .mem_wdata
  );

  rbb_line_mem u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  rbb_back u_back (
    .clk, .rst_n, .job_valid, .job, .job_pop, .busy(back_busy), .mem_raddr,
    .mem_rdata, .out_valid, .out_ready, .out_red_out, .out_green_out,
    .out_blue_out, .out_frame_end
  );

  `RBB_ASSERT(a_no_input_while_reading, back_busy |-> !in_ready)
  `RBB_ASSERT(a_pop_starts_read, job_pop |=> back_busy)
  `RBB_ASSERT(a_store_only_when_open, mem_we |-> in_ready && in_valid)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB box blur unit testbench
// Streams small frames through the blur unit under several radius and size
// settings and compares every output pixel with a clipped-window mean model.
// ----------------------------------------------------------------------------
module tb_top;
  import rbb_pkg::*;

  typedef struct packed {
    logic       op;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } blur_px_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = 1'b0;
  logic [7:0]  in_red_in = '0;
  logic [7:0]  in_green_in = '0;
  logic [7:0]  in_blue_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        out_frame_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  rgb_box_blur_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state
  logic [23:0] img [0:31][0:MAX_WIDTH-1];
  int unsigned m_rad, m_w, m_h;
  int unsigned in_col, in_row, o_row, o_col;

  pix_req_t pending_q[$];
  blur_px_t blurred_q[$];
  int  send_idle_pct, recv_stall_pct;
  int  n_errors, n_checked, n_frames, n_sent;

  function automatic int unsigned umin(int unsigned a, int unsigned b);
    return a < b ? a : b;
  endfunction

  task automatic apply_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == CFG_RADIUS) m_rad = val[3:0];
    else if (idx == CFG_WIDTH) m_w = val[10:0];
    else if (idx == CFG_HEIGHT) m_h = val;
    else return;
    in_col = 0; in_row = 0; o_row = 0; o_col = 0;
  endtask

  task automatic predict_blur(pix_req_t q);
    int unsigned r, w, h, nr, nc, r0, c0, sr, sg, sb, n;
    blur_px_t res;
    r = m_rad > MAX_RADIUS ? MAX_RADIUS : m_rad;
    w = m_w == 0 ? 1 : (m_w > MAX_WIDTH ? MAX_WIDTH : m_w);
    h = m_h == 0 ? 1 : m_h;
    if (q.op == OP_PIXEL && in_row < h) begin
      img[in_row % 32][in_col] = {q.r, q.g, q.b};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    nr = umin(o_row + r, h - 1);
    nc = umin(o_col + r, w - 1);
    if (!(in_row > nr || (in_row == nr && in_col > nc))) return;
    r0 = o_row >= r ? o_row - r : 0;
    c0 = o_col >= r ? o_col - r : 0;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int unsigned y = r0; y <= nr; y++)
      for (int unsigned x = c0; x <= nc; x++) begin
        sr += img[y % 32][x][23:16];
        sg += img[y % 32][x][15:8];
        sb += img[y % 32][x][7:0];
        n++;
      end
    res.r = 8'(sr / n);
    res.g = 8'(sg / n);
    res.b = 8'(sb / n);
    res.fe = (o_row == h - 1) && (o_col == w - 1);
    blurred_q.push_back(res);
    if (res.fe) begin
      in_col = 0; in_row = 0; o_row = 0; o_col = 0;
      n_frames++;
    end else begin
      o_col++;
      if (o_col >= w) begin
        o_col = 0;
        o_row++;
      end
    end
  endtask

  // Driver: predicts at acceptance so the model follows the accepted order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_blur({in_opcode, in_red_in, in_green_in, in_blue_in});
        n_sent++;
      end
      if ((!in_valid || in_ready) && pending_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        pix_req_t q;
        q = pending_q.pop_front();
        in_valid <= 1'b1;
        in_opcode <= q.op;
        in_red_in <= q.r;
        in_green_in <= q.g;
        in_blue_in <= q.b;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
      out_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      blur_px_t got, want;
      got = {out_red_out, out_green_out, out_blue_out, out_frame_end};
      if (blurred_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected output pixel %h", got);
      end else begin
        want = blurred_q.pop_front();
        n_checked++;
        if (got != want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("pixel %0d: expected r%h g%h b%h fe%b, got r%h g%h b%h fe%b",
                     n_checked, want.r, want.g, want.b, want.fe,
                     got.r, got.g, got.b, got.fe);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || blurred_q.size() > 0)
      @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic push_px(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pending_q.push_back({op, r, g, b});
  endtask

  // One frame of random or flat pixels, a few noise drains mixed in, then enough
  // drains to release every output still pending behind the window.
  task automatic push_frame(int unsigned w, int unsigned h, bit flat);
    int unsigned lag;
    lag = umin(m_rad, h - 1) * w + m_rad + 4;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(19) == 0)
        push_px(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      if (flat) push_px(OP_PIXEL, 8'hff, 8'h00, 8'hff);
      else push_px(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    for (int unsigned i = 0; i < lag; i++)
      push_px(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic run_setting(logic [15:0] rad, logic [15:0] w, logic [15:0] h,
                             int frames, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    for (int f = 0; f < frames; f++) push_frame(m_w, m_h, 1'b0);
    wait_idle();
  endtask

  initial begin
    n_errors = 0; n_checked = 0; n_frames = 0; n_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    m_rad = 3; m_w = 1024; m_h = 768;
    in_col = 0; in_row = 0; o_row = 0; o_col = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single pixel frame, flat extremes, radius zero, wide radius.
    write_reg(CFG_RADIUS, 16'd0);
    write_reg(CFG_WIDTH, 16'd1);
    write_reg(CFG_HEIGHT, 16'd1);
    push_px(1'b1, 8'h00, 8'h00, 8'h00);
    push_px(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    push_px(OP_PIXEL, 8'h12, 8'h34, 8'h56);
    push_px(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    push_px(1'b1, 8'hff, 8'hff, 8'hff);
    wait_idle();
    write_reg(CFG_RADIUS, 16'd15);
    write_reg(CFG_WIDTH, 16'd3);
    write_reg(CFG_HEIGHT, 16'd2);
    push_frame(3, 2, 1'b1);
    wait_idle();
    // Abandon a frame mid-way; out-of-range register values are truncated or clamped.
    write_reg(CFG_WIDTH, 16'd4);
    write_reg(CFG_HEIGHT, 16'd4);
    push_px(OP_PIXEL, 8'h55, 8'haa, 8'h0f);
    wait_idle();
    write_reg(CFG_RADIUS, 16'hfff1);
    write_reg(CFG_WIDTH, 16'd0);
    write_reg(CFG_HEIGHT, 16'd0);
    push_frame(1, 1, 1'b0);
    wait_idle();
    write_reg(CFG_WIDTH, 16'h07ff);
    write_reg(CFG_HEIGHT, 16'd1);
    write_reg(CFG_RADIUS, 16'd1);
    push_frame(MAX_WIDTH, 1, 1'b0);
    wait_idle();
    write_reg(CFG_WIDTH, 16'd2);
    write_reg(CFG_HEIGHT, 16'hffff);
    for (int i = 0; i < 20; i++)
      push_px(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    wait_idle();

    // Random: several settings under varied sender idle and receiver stall rates.
    run_setting(16'd1, 16'd8, 16'd6, 1, 0, 0);
    run_setting(16'd2, 16'd7, 16'd5, 1, 78, 0);
    run_setting(16'd3, 16'd9, 16'd7, 1, 0, 78);
    run_setting(16'd15, 16'd5, 16'd12, 1, 33, 33);
    run_setting(16'd0, 16'd16, 16'd4, 1, 0, 0);
    run_setting(16'd4, 16'd12, 16'd6, 1, 33, 33);
    run_setting(16'd2, 16'd1, 16'd35, 2, 78, 78);

    $display("sent %0d requests over %0d frames, checked %0d output pixels",
             n_sent, n_frames, n_checked);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("mismatches: %0d", n_errors);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
